@@ rtl/core/lwgc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwgc_pkg: shared types and constants for the widest-gap centroid block
// Field widths, register indexes, reset values and the control/status
// structs passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package lwgc_pkg;

    localparam int RANGE_W   = 16;  // beam range in mm
    localparam int IDX_OUT_W = 12;  // reported beam index
    localparam int SUM_W     = 28;  // range sum
    localparam int WSUM_W    = 40;  // index-weighted range sum
    localparam int CEN_W     = 20;  // centroid, fixed point
    localparam int CFG_IDX_W = 1;
    localparam int OUT_DATA_W = 72; // four result fields, whole bytes
    localparam int OUT_USER_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_SAFE_DISTANCE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_RANGE     = 1'd1;

    localparam logic [RANGE_W-1:0] SAFE_DISTANCE_RST = 16'd300;
    localparam logic [RANGE_W-1:0] MAX_RANGE_RST     = 16'd10000;

    // Commands from the controller
    typedef struct packed {
        logic accept_en;  // take beams
        logic div_start;  // load the divider from the best run
        logic load_out;   // capture the result word
        logic clear;      // wipe scan state for the next field of view
    } lwgc_cmd_t;

    // Status back to the controller
    typedef struct packed {
        logic scan_done;  // last beam has left the accumulate stage
        logic empty;      // best run sum is zero
        logic div_done;   // final quotient step happens this cycle
        logic out_free;   // output register can take a word
    } lwgc_status_t;

endpackage

@@ rtl/core/lidar_widest_gap_centroid.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lidar_widest_gap_centroid: widest free gap of a lidar scan and its centroid
// Finds the run of unblocked beams with the largest clamped range sum and
// reports its bounds, sum and range-weighted centroid beam index.
// ----------------------------------------------------------------------------
// Usage
//   Slave stream: one beam per word, range in mm on s_tdata, s_tlast on the
//   final beam of the field of view. Beams are taken one per cycle while s_tready is high.
//   Master stream: one result word per field of view, emitted after the beam
//   carrying s_tlast. m_tuser flags an empty scan and a beam overflow.
//   Configuration: cfg_we writes safe distance (index 0) or max range
//   (index 1); write only between scans.
// Timing
//   Intake is one beam per cycle until s_tlast. The last beam then runs
//   through three pipeline stages and a restoring divider that produces one
//   quotient bit per cycle; an empty scan skips the divider. s_tready is low
//   from the last beam until the result word is loaded.
// Reset and stall
//   Reset clears the scan state and restores the register defaults (300 mm,
//   10000 mm). A result held by a stalled receiver stays in the output
//   register; the next scan is taken meanwhile, and its result waits for it.
// ----------------------------------------------------------------------------
module lidar_widest_gap_centroid
    import lwgc_pkg::*;
#(
    parameter int MAX_BEAMS = 4096,
    parameter int FRAC_BITS = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [RANGE_W-1:0]    cfg_wdata,
    // beam stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [RANGE_W-1:0]    s_tdata,   // [15:0] range_mm
    input  logic                  s_tlast,   // last_beam
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // [11:0] gap_start, [23:12] gap_end,
                                             // [51:24] gap_range_sum,
                                             // [71:52] centroid_index_q8
    output logic [OUT_USER_W-1:0] m_tuser    // [0] gap_empty, [1] beam_overflow
);

    lwgc_cmd_t    cmd;
    lwgc_status_t status;

    // Sequencer: intake, drain, divide, hand off
    lwgc_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .status   (status),
        .cmd      (cmd)
    );

    // Beam pipeline, run tracking, divider and result register
    lwgc_datapath #(
        .MAX_BEAMS (MAX_BEAMS),
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .range_mm  (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // beams are taken only in the intake state
    assign s_tready = cmd.accept_en;

endmodule

@@ rtl/core/lwgc_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwgc_ctrl: scan sequencer
// Steps through beam intake, pipeline drain, centroid division and result
// hand-off, issuing commands to the datapath.
// ----------------------------------------------------------------------------
module lwgc_ctrl
    import lwgc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tlast,
    input  lwgc_status_t status,
    output lwgc_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_ACCUM,
        ST_DRAIN,
        ST_DIVIDE,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_ACCUM:
            begin
                cmd.accept_en = 1'b1;
                if (s_tvalid && s_tlast)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (status.scan_done)
                begin
                    if (status.empty)
                    begin
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        cmd.div_start = 1'b1;
                        state_next    = ST_DIVIDE;
                    end
                end
            end
            ST_DIVIDE:
            begin
                if (status.div_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    cmd.clear    = 1'b1;
                    state_next   = ST_ACCUM;
                end
            end
            default:
            begin
                state_next = ST_ACCUM;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_ACCUM;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/core/lwgc_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwgc_datapath: beam pipeline, run tracking, divider and output register
// Clamp, multiply and accumulate stages, best-run registers, a restoring
// divider one quotient bit per cycle, and the result register.
// ----------------------------------------------------------------------------
module lwgc_datapath
    import lwgc_pkg::*;
#(
    parameter int MAX_BEAMS = 4096,
    parameter int FRAC_BITS = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  lwgc_cmd_t             cmd,
    output lwgc_status_t          status,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [RANGE_W-1:0]    cfg_wdata,
    input  logic                  s_tvalid,
    input  logic [RANGE_W-1:0]    range_mm,
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic [OUT_USER_W-1:0] m_tuser
);

    localparam int IDX_W  = $clog2(MAX_BEAMS);
    localparam int CNT_W  = $clog2(MAX_BEAMS + 1);
    localparam int PROD_W = RANGE_W + IDX_W;
    localparam int DIVW   = WSUM_W + FRAC_BITS;
    localparam int DCNT_W = $clog2(DIVW + 1);

    // Configuration
    logic [RANGE_W-1:0] safe_reg;
    logic [RANGE_W-1:0] max_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            safe_reg <= SAFE_DISTANCE_RST;
            max_reg  <= MAX_RANGE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SAFE_DISTANCE: safe_reg <= cfg_wdata;
                REG_MAX_RANGE:     max_reg  <= cfg_wdata;
                default:           ;
            endcase
        end
    end

    // Stage 0: count and clamp
    logic [CNT_W-1:0]   beam_cnt_reg;
    logic               accept;
    logic               in_range;
    logic [RANGE_W-1:0] clamp_c;

    assign accept   = s_tvalid && cmd.accept_en;
    assign in_range = beam_cnt_reg < CNT_W'(MAX_BEAMS);

    always_comb
    begin
        if (range_mm <= safe_reg)
        begin
            clamp_c = '0;
        end
        else if (range_mm <= max_reg)
        begin
            clamp_c = range_mm;
        end
        else
        begin
            clamp_c = max_reg;
        end
    end

    logic               s1_valid_reg;
    logic               s1_last_reg;
    logic               s1_used_reg;
    logic [RANGE_W-1:0] s1_c_reg;
    logic [IDX_W-1:0]   s1_idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            beam_cnt_reg <= '0;
        end
        else
        begin
            s1_valid_reg <= accept;
            if (cmd.clear)
            begin
                beam_cnt_reg <= '0;
            end
            else if (accept && in_range)
            begin
                beam_cnt_reg <= beam_cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_last_reg <= s_tlast;
            s1_used_reg <= in_range;
            s1_c_reg    <= clamp_c;
            s1_idx_reg  <= beam_cnt_reg[IDX_W-1:0];
        end
    end

    // Stage 1: weight by beam index
    logic                 s2_valid_reg;
    logic                 s2_last_reg;
    logic                 s2_used_reg;
    logic [RANGE_W-1:0]   s2_c_reg;
    logic [IDX_OUT_W-1:0] s2_idx_reg;
    logic [PROD_W-1:0]    s2_prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            s2_last_reg <= s1_last_reg;
            s2_used_reg <= s1_used_reg;
            s2_c_reg    <= s1_c_reg;
            s2_idx_reg  <= IDX_OUT_W'(s1_idx_reg);
            s2_prod_reg <= PROD_W'(s1_c_reg) * PROD_W'(s1_idx_reg);
        end
    end

    // Stage 2: run tracking and best-run update
    logic                 in_gap_reg,     in_gap_next;
    logic [IDX_OUT_W-1:0] run_start_reg,  run_start_next;
    logic [IDX_OUT_W-1:0] run_end_reg,    run_end_next;
    logic [SUM_W-1:0]     run_sum_reg,    run_sum_next;
    logic [WSUM_W-1:0]    run_wsum_reg,   run_wsum_next;
    logic [IDX_OUT_W-1:0] best_start_reg, best_start_next;
    logic [IDX_OUT_W-1:0] best_end_reg,   best_end_next;
    logic [SUM_W-1:0]     best_sum_reg,   best_sum_next;
    logic [WSUM_W-1:0]    best_wsum_reg,  best_wsum_next;
    logic                 ovf_reg,        ovf_next;
    logic                 done_reg;
    logic [SUM_W:0]       sum_ext;
    logic [WSUM_W:0]      wsum_ext;
    logic                 c_nz;
    logic                 close_run;

    always_comb
    begin
        in_gap_next     = in_gap_reg;
        run_start_next  = run_start_reg;
        run_end_next    = run_end_reg;
        run_sum_next    = run_sum_reg;
        run_wsum_next   = run_wsum_reg;
        best_start_next = best_start_reg;
        best_end_next   = best_end_reg;
        best_sum_next   = best_sum_reg;
        best_wsum_next  = best_wsum_reg;
        ovf_next        = ovf_reg || (s2_valid_reg && !s2_used_reg);
        c_nz            = s2_c_reg != '0;
        sum_ext         = {1'b0, run_sum_reg} + (SUM_W + 1)'(s2_c_reg);
        wsum_ext        = {1'b0, run_wsum_reg} + (WSUM_W + 1)'(s2_prod_reg);

        if (s2_valid_reg && s2_used_reg && c_nz)
        begin
            if (!in_gap_reg)
            begin
                run_start_next = s2_idx_reg;
                run_sum_next   = SUM_W'(s2_c_reg);
                run_wsum_next  = WSUM_W'(s2_prod_reg);
            end
            else
            begin
                // saturate both sums
                run_sum_next  = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
                run_wsum_next = wsum_ext[WSUM_W] ? '1 : wsum_ext[WSUM_W-1:0];
            end
            run_end_next = s2_idx_reg;
            in_gap_next  = 1'b1;
        end

        // a blocked beam or the last beam closes an open run
        close_run = s2_valid_reg
                    && ((s2_used_reg && !c_nz && in_gap_reg) || (s2_last_reg && in_gap_next));

        if (close_run)
        begin
            in_gap_next = 1'b0;
            if (run_sum_next > best_sum_reg)
            begin
                best_start_next = run_start_next;
                best_end_next   = run_end_next;
                best_sum_next   = run_sum_next;
                best_wsum_next  = run_wsum_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_gap_reg     <= 1'b0;
            run_start_reg  <= '0;
            run_end_reg    <= '0;
            run_sum_reg    <= '0;
            run_wsum_reg   <= '0;
            best_start_reg <= '0;
            best_end_reg   <= '0;
            best_sum_reg   <= '0;
            best_wsum_reg  <= '0;
            ovf_reg        <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            done_reg <= s2_valid_reg && s2_last_reg;
            if (cmd.clear)
            begin
                in_gap_reg     <= 1'b0;
                run_start_reg  <= '0;
                run_end_reg    <= '0;
                run_sum_reg    <= '0;
                run_wsum_reg   <= '0;
                best_start_reg <= '0;
                best_end_reg   <= '0;
                best_sum_reg   <= '0;
                best_wsum_reg  <= '0;
                ovf_reg        <= 1'b0;
            end
            else
            begin
                in_gap_reg     <= in_gap_next;
                run_start_reg  <= run_start_next;
                run_end_reg    <= run_end_next;
                run_sum_reg    <= run_sum_next;
                run_wsum_reg   <= run_wsum_next;
                best_start_reg <= best_start_next;
                best_end_reg   <= best_end_next;
                best_sum_reg   <= best_sum_next;
                best_wsum_reg  <= best_wsum_next;
                ovf_reg        <= ovf_next;
            end
        end
    end

    // Restoring divider: dividend shifts out of dq, quotient shifts in
    logic              div_busy_reg;
    logic [DCNT_W-1:0] div_cnt_reg;
    logic [SUM_W-1:0]  rem_reg;
    logic [DIVW-1:0]   dq_reg;
    logic [SUM_W:0]    rem_sh;
    logic [SUM_W:0]    rem_diff;
    logic              q_bit;

    assign rem_sh   = {rem_reg, dq_reg[DIVW-1]};
    assign rem_diff = rem_sh - {1'b0, best_sum_reg};
    assign q_bit    = rem_sh >= {1'b0, best_sum_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_busy_reg <= 1'b0;
            div_cnt_reg  <= '0;
        end
        else if (cmd.div_start)
        begin
            div_busy_reg <= 1'b1;
            div_cnt_reg  <= DCNT_W'(DIVW);
        end
        else if (div_busy_reg)
        begin
            div_cnt_reg <= div_cnt_reg - DCNT_W'(1);
            if (div_cnt_reg == DCNT_W'(1))
            begin
                div_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            rem_reg <= '0;
            dq_reg  <= DIVW'(best_wsum_reg) << FRAC_BITS;
        end
        else if (div_busy_reg)
        begin
            rem_reg <= q_bit ? rem_diff[SUM_W-1:0] : rem_sh[SUM_W-1:0];
            dq_reg  <= {dq_reg[DIVW-2:0], q_bit};
        end
    end

    // Result register
    logic                  empty;
    logic [CEN_W-1:0]      cen_sat;
    logic                  m_tvalid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [OUT_USER_W-1:0] out_user_reg;

    assign empty   = best_sum_reg == '0;
    assign cen_sat = (|dq_reg[DIVW-1:CEN_W]) ? '1 : dq_reg[CEN_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_data_reg <= {empty ? {CEN_W{1'b0}} : cen_sat,
                             best_sum_reg,
                             empty ? {IDX_OUT_W{1'b0}} : best_end_reg,
                             empty ? {IDX_OUT_W{1'b0}} : best_start_reg};
            out_user_reg <= {ovf_reg, empty};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    assign status.scan_done = done_reg;
    assign status.empty     = empty;
    assign status.div_done  = div_busy_reg && (div_cnt_reg == DCNT_W'(1));
    assign status.out_free  = !m_tvalid_reg || m_tready;

endmodule

@@ rtl/core/lwgc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwgc_checker: port-level checks for the widest-gap centroid block
// Watches the stream ports over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
module lwgc_checker
    import lwgc_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  s_tlast,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic [OUT_USER_W-1:0] m_tuser
);

    // a stalled result word holds
    hold_stalled_word: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // intake stops after the last beam of a scan
    stop_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("beam taken straight after the last beam");

    // an empty scan reports all-zero fields
    empty_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
        else $error("empty scan with nonzero fields");

    // a non-empty scan has a nonzero sum
    gap_has_sum: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata[51:24] != '0)
        else $error("gap reported with zero range sum");

endmodule

bind lidar_widest_gap_centroid lwgc_checker u_lwgc_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for lidar_widest_gap_centroid
// Streams lidar scans into the block and predicts each scan's best gap,
// range sum, Q8 centroid and flags from a cycle-free model held here. Every
// result word is compared field by field with the oldest prediction. Both
// stream sides idle at random, and one stretch holds the result side off long
// enough to back the block up into its beam input.
// ----------------------------------------------------------------------------
module testbench;
    import lwgc_pkg::*;

    localparam int   CLK_PERIOD    = 8;
    localparam int   BEAM_LIMIT    = 4096;      // MAX_BEAMS of the instance
    localparam int   Q_FRAC        = 8;         // FRAC_BITS of the instance
    localparam int   SETTLE_CYCLES = 64;        // divider plus pipeline, rounded up
    localparam int   RANDOM_BEAMS  = 380;
    localparam int   ERR_SHOWN     = 10;

    typedef longint unsigned u64_t;

    localparam u64_t SUM_CAP  = (u64_t'(1) << SUM_W) - 1;
    localparam u64_t WSUM_CAP = (u64_t'(1) << WSUM_W) - 1;
    localparam u64_t CEN_CAP  = (u64_t'(1) << CEN_W) - 1;

    // One result word, unpacked
    typedef struct packed {
        logic [IDX_OUT_W-1:0] start_idx;
        logic [IDX_OUT_W-1:0] end_idx;
        logic [SUM_W-1:0]     gap_sum;
        logic [CEN_W-1:0]     centroid;
        logic                 empty;
        logic                 overflow;
    } gap_result_t;

    // ------------------------------------------------------------------------
    // Clock, reset and block ports; every input starts at a known value
    // ------------------------------------------------------------------------
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_SAFE_DISTANCE;
    logic [RANGE_W-1:0]    cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [RANGE_W-1:0]    s_tdata   = '0;   // [15:0] range_mm
    logic                  s_tlast   = 1'b0; // last_beam
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;          // [11:0] gap_start, [23:12] gap_end,
                                             // [51:24] gap_range_sum,
                                             // [71:52] centroid_index_q8
    logic [OUT_USER_W-1:0] m_tuser;          // [0] gap_empty, [1] beam_overflow

    always #(CLK_PERIOD / 2) clk = ~clk;

    lidar_widest_gap_centroid #(
        .MAX_BEAMS (BEAM_LIMIT),
        .FRAC_BITS (Q_FRAC)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // ------------------------------------------------------------------------
    // Gap tracker: the bench's own view of the registers and scan state
    // ------------------------------------------------------------------------
    logic [RANGE_W-1:0]   safe_mm;
    logic [RANGE_W-1:0]   max_mm;
    int unsigned          beams_seen;
    logic                 in_run;
    logic [IDX_OUT_W-1:0] run_first;
    logic [IDX_OUT_W-1:0] run_last;
    logic [SUM_W-1:0]     run_sum;
    logic [WSUM_W-1:0]    run_wsum;
    logic [IDX_OUT_W-1:0] best_first;
    logic [IDX_OUT_W-1:0] best_last;
    logic [SUM_W-1:0]     best_sum;
    logic [WSUM_W-1:0]    best_wsum;
    logic                 ovf_seen;

    gap_result_t pending_gaps[$];   // predicted result words, oldest first
    int unsigned mismatches = 0;

    // Stimulus controls shared with the result side
    logic        tx_idle_on = 1'b1;
    logic        rx_idle_on = 1'b1;
    int unsigned rx_hold    = 0;    // cycles the result side still holds off

    function automatic u64_t sat_add(input u64_t a, input u64_t b, input u64_t cap);
        u64_t s;
        s = a + b;
        return (s > cap) ? cap : s;
    endfunction

    task automatic clear_scan();
        beams_seen = 0;
        in_run     = 1'b0;
        run_first  = '0;
        run_last   = '0;
        run_sum    = '0;
        run_wsum   = '0;
        best_first = '0;
        best_last  = '0;
        best_sum   = '0;
        best_wsum  = '0;
        ovf_seen   = 1'b0;
    endtask

    // Close the open run; a later run must beat the best strictly, so ties
    // keep the earlier one
    task automatic close_run();
        in_run = 1'b0;
        if (run_sum > best_sum)
        begin
            best_first = run_first;
            best_last  = run_last;
            best_sum   = run_sum;
            best_wsum  = run_wsum;
        end
    endtask

    // Fold one accepted beam into the scan; on the last beam queue the result
    task automatic fold_beam(input logic [RANGE_W-1:0] r, input logic last);
        logic [RANGE_W-1:0] c;
        gap_result_t        res;
        u64_t               quo;
        if (beams_seen < BEAM_LIMIT)
        begin
            if (r <= safe_mm)
                c = '0;
            else if (r <= max_mm)
                c = r;
            else
                c = max_mm;
            if (c != 0)
            begin
                if (!in_run)
                begin
                    run_first = IDX_OUT_W'(beams_seen);
                    run_sum   = '0;
                    run_wsum  = '0;
                    in_run    = 1'b1;
                end
                run_sum  = SUM_W'(sat_add(u64_t'(run_sum), u64_t'(c), SUM_CAP));
                run_wsum = WSUM_W'(sat_add(u64_t'(run_wsum),
                                           u64_t'(c) * u64_t'(beams_seen), WSUM_CAP));
                run_last = IDX_OUT_W'(beams_seen);
            end
            else if (in_run)
            begin
                close_run();
            end
            beams_seen++;
        end
        else
        begin
            // past the beam limit: range dropped, only the flag and the mark count
            ovf_seen = 1'b1;
        end

        if (last)
        begin
            if (in_run)
                close_run();
            res = '0;
            if (best_sum == 0)
            begin
                res.empty = 1'b1;
            end
            else
            begin
                quo = (u64_t'(best_wsum) << Q_FRAC) / u64_t'(best_sum);
                if (quo > CEN_CAP)
                    quo = CEN_CAP;
                res.start_idx = best_first;
                res.end_idx   = best_last;
                res.gap_sum   = best_sum;
                res.centroid  = CEN_W'(quo);
            end
            res.overflow = ovf_seen;
            pending_gaps = {pending_gaps, res};
            clear_scan();
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side: drive m_tready, check each word taken
    // ------------------------------------------------------------------------
    initial
    begin : result_sink
        forever
        begin
            @(negedge clk);
            if (rx_hold != 0)
            begin
                m_tready <= 1'b0;
                rx_hold--;
            end
            else if (rx_idle_on)
            begin
                m_tready <= ($urandom_range(99) >= 30);
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic flag_error(input string msg);
        mismatches++;
        if (mismatches <= ERR_SHOWN)
            $display("%0t mismatch %0d: %s", $realtime, mismatches, msg);
    endtask

    task automatic check_field(input string name, input u64_t want, input u64_t got);
        if (want != got)
            flag_error($sformatf("%s expected %0d, got %0d", name, want, got));
    endtask

    // Sample in the active region of the rising edge: outputs still hold
    // their pre-edge values here
    always @(posedge clk)
    begin : result_check
        gap_result_t got;
        gap_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.start_idx = m_tdata[11:0];
            got.end_idx   = m_tdata[23:12];
            got.gap_sum   = m_tdata[51:24];
            got.centroid  = m_tdata[71:52];
            got.empty     = m_tuser[0];
            got.overflow  = m_tuser[1];
            if (pending_gaps.size() == 0)
            begin
                flag_error($sformatf("result word with nothing expected: %h / %b",
                                     m_tdata, m_tuser));
            end
            else
            begin
                want = pending_gaps.pop_front();
                check_field("gap_start", want.start_idx, got.start_idx);
                check_field("gap_end", want.end_idx, got.end_idx);
                check_field("gap_range_sum", want.gap_sum, got.gap_sum);
                check_field("centroid_index_q8", want.centroid, got.centroid);
                check_field("gap_empty", want.empty, got.empty);
                check_field("beam_overflow", want.overflow, got.overflow);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Beam side
    // ------------------------------------------------------------------------

    // Offer one beam word, idling first at random; hold it until taken.
    // Valid stays high afterwards so back-to-back words need no extra cycle.
    task automatic send_beam(input logic [RANGE_W-1:0] r, input logic last);
        @(negedge clk);
        if (tx_idle_on && $urandom_range(99) < 30)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= r;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        fold_beam(r, last);
    endtask

    // Drop valid, drain every expected word, then let the divider go quiet
    task automatic wait_idle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_gaps.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write both registers back to back; only call when the block is idle
    task automatic set_config(input logic [RANGE_W-1:0] safe, input logic [RANGE_W-1:0] max);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_SAFE_DISTANCE;
        cfg_wdata <= safe;
        @(negedge clk);
        cfg_index <= REG_MAX_RANGE;
        cfg_wdata <= max;
        @(negedge clk);
        cfg_we    <= 1'b0;
        safe_mm = safe;
        max_mm  = max;
    endtask

    // Mix of blocked, boundary, in-band and arbitrary ranges for the current
    // register setting
    function automatic logic [RANGE_W-1:0] pick_range();
        logic [RANGE_W-1:0] r;
        case ($urandom_range(9))
            0:       r = '0;
            1:       r = '1;
            2:       r = RANGE_W'($urandom_range(safe_mm));
            3:       r = safe_mm + 16'd1;
            4:       r = max_mm;
            5:       r = max_mm + 16'd1;
            6, 7:    r = RANGE_W'($urandom_range(safe_mm, max_mm));
            default: r = RANGE_W'($urandom_range(16'hFFFF));
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Default registers: empty scans, clamping boundaries, ties, run closing
    // on the last beam
    task automatic test_directed_scans();
        wait_idle();
        // lone blocked beam, then lone no-return beam clamped to max range
        send_beam(16'd0, 1'b1);
        send_beam(16'hFFFF, 1'b1);
        // at safe distance, just above, at max, just above max; closed by a block
        send_beam(16'd300, 1'b0);
        send_beam(16'd301, 1'b0);
        send_beam(16'd10000, 1'b0);
        send_beam(16'd10001, 1'b0);
        send_beam(16'd300, 1'b1);
        // equal sums: the earlier run must be kept
        send_beam(16'd1000, 1'b0);
        send_beam(16'd0, 1'b0);
        send_beam(16'd400, 1'b0);
        send_beam(16'd600, 1'b0);
        send_beam(16'd0, 1'b1);
        // larger run still open when the last beam arrives
        send_beam(16'd500, 1'b0);
        send_beam(16'd0, 1'b0);
        send_beam(16'd200, 1'b0);
        send_beam(16'd200, 1'b0);
        send_beam(16'd200, 1'b1);
        // everything blocked over several beams
        send_beam(16'd0, 1'b0);
        send_beam(16'd299, 1'b0);
        send_beam(16'd300, 1'b1);
    endtask

    // Register extremes, and a max range below the safe distance
    task automatic test_register_extremes();
        wait_idle();
        set_config(16'd0, 16'hFFFF);
        send_beam(16'd0, 1'b0);
        send_beam(16'd1, 1'b0);
        send_beam(16'hFFFF, 1'b0);
        send_beam(16'd0, 1'b0);
        send_beam(16'h8000, 1'b1);
        wait_idle();
        set_config(16'hFFFF, 16'hFFFF);
        send_beam(16'hFFFF, 1'b0);
        send_beam(16'd12345, 1'b1);
        wait_idle();
        // anything above the safe distance lands on the smaller max range
        set_config(16'd5000, 16'd1000);
        send_beam(16'd6000, 1'b0);
        send_beam(16'hFFFF, 1'b0);
        send_beam(16'd4000, 1'b0);
        send_beam(16'd5001, 1'b1);
        wait_idle();
        // zero max range blocks every beam
        set_config(16'd100, 16'd0);
        send_beam(16'd200, 1'b0);
        send_beam(16'hFFFF, 1'b1);
    endtask

    // Random scans over several register settings, one phase with no idling
    task automatic test_random_scans();
        int unsigned sent;
        int unsigned len;
        int unsigned k;
        int          phase;
        sent = 0;
        for (phase = 0; phase < 5; phase++)
        begin
            wait_idle();
            case (phase)
                0: set_config(SAFE_DISTANCE_RST, MAX_RANGE_RST);
                1: set_config(RANGE_W'($urandom_range(2000)),
                              RANGE_W'($urandom_range(2000, 65535)));
                2: set_config(RANGE_W'($urandom_range(65535)),
                              RANGE_W'($urandom_range(65535)));
                3:
                begin
                    set_config(RANGE_W'($urandom_range(1000)),
                               RANGE_W'($urandom_range(1000, 30000)));
                    tx_idle_on = 1'b0;
                    rx_idle_on = 1'b0;
                end
                default: set_config(RANGE_W'($urandom_range(600)),
                                    RANGE_W'($urandom_range(600, 20000)));
            endcase
            while (sent < (phase + 1) * (RANDOM_BEAMS / 5))
            begin
                // mostly short scans, now and then a longer one
                len = ($urandom_range(9) == 0) ? $urandom_range(13, 48)
                                               : $urandom_range(1, 12);
                for (k = 0; k < len; k++)
                    send_beam(pick_range(), k == len - 1);
                sent += len;
            end
            tx_idle_on = 1'b1;
            rx_idle_on = 1'b1;
        end
    endtask

    // Hold the result side off while short scans keep coming, so the output
    // register fills and the beam input stalls
    task automatic test_output_backpressure();
        int unsigned n;
        int unsigned len;
        int unsigned k;
        wait_idle();
        set_config(SAFE_DISTANCE_RST, MAX_RANGE_RST);
        rx_hold = 400;
        for (n = 0; n < 8; n++)
        begin
            len = $urandom_range(2, 6);
            for (k = 0; k < len; k++)
                send_beam(pick_range(), k == len - 1);
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin : run_tests
        safe_mm = SAFE_DISTANCE_RST;
        max_mm  = MAX_RANGE_RST;
        clear_scan();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_scans();
        test_register_extremes();
        test_random_scans();
        test_output_backpressure();
        wait_idle();

        if (mismatches == 0)
            $display("[lidar_widest_gap_centroid] OK");
        else
            $display("[lidar_widest_gap_centroid] ERROR");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run
    initial
    begin : watchdog
        #4_000_000;
        $display("[lidar_widest_gap_centroid] ERROR");
        $finish;
    end

endmodule
